// ----- sv/dpc_pkg.sv -----
`timescale 1ns / 1ps

package dpc_pkg;

    localparam int COL_W      = 9;
    localparam int ROW_W      = 8;
    localparam int FLOW_W     = 16;
    localparam int LEVEL_W    = 8;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int COEF_W     = 16;
    localparam int OFFS_W     = 32;
    localparam int DIST_W     = 15;
    localparam int GAIN_W     = 17;

    localparam int PROD_W     = 27;
    localparam int Q_W        = 36;
    localparam int PRED_W     = 26;
    localparam int DIFF_W     = 27;
    localparam int SQ_W       = 54;
    localparam int SUMSQ_W    = 55;
    localparam int LIM_SQ_W   = 2 * DIST_W;
    localparam int FILT_W     = 25;

    localparam logic [GAIN_W-1:0]  UNITY_GAIN = GAIN_W'(65536);
    localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(255);

    localparam logic [DIST_W-1:0]  MATCH_DISTANCE_RST = DIST_W'(64);
    localparam logic [GAIN_W-1:0]  SMOOTHING_GAIN_RST = GAIN_W'(32768);
    localparam logic [LEVEL_W-1:0] MASK_THRESHOLD_RST = LEVEL_W'(100);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAIN_ROW0      = 3'd0,
        CFG_MAIN_ROW1      = 3'd1,
        CFG_SECOND_ROW0    = 3'd2,
        CFG_SECOND_ROW1    = 3'd3,
        CFG_MATCH_DISTANCE = 3'd4,
        CFG_SMOOTHING_GAIN = 3'd5,
        CFG_MASK_THRESHOLD = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_lane_en;

endpackage

// ----- sv/dpc_plane_lane.sv -----
`timescale 1ns / 1ps

module dpc_plane_lane
    import dpc_pkg::*;
(
    input  logic                       i_clk,
    input  t_lane_en                   i_en,
    input  logic [COL_W-1:0]           i_col,
    input  logic [ROW_W-1:0]           i_row,
    input  logic signed [FLOW_W-1:0]   i_flow_x,
    input  logic signed [FLOW_W-1:0]   i_flow_y,
    input  logic [CFG_W-1:0]           i_row0_model,
    input  logic [CFG_W-1:0]           i_row1_model,
    input  logic [LIM_SQ_W-1:0]        i_lim_sq,
    output logic                       o_hit,
    output logic signed [FLOW_W-1:0]   o_pred_x,
    output logic signed [FLOW_W-1:0]   o_pred_y
);

    localparam logic signed [PRED_W-1:0] SAT_HI = PRED_W'(2**(FLOW_W-1) - 1);
    localparam logic signed [PRED_W-1:0] SAT_LO = -PRED_W'(2**(FLOW_W-1));
    localparam logic signed [Q_W-1:0]    ROUND_HALF = Q_W'(512);

    function automatic logic signed [FLOW_W-1:0] sat_flow(input logic signed [PRED_W-1:0] v);
        logic signed [FLOW_W-1:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[FLOW_W-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[FLOW_W-1:0];
        end else begin
            res = v[FLOW_W-1:0];
        end
        return res;
    endfunction

    logic signed [COEF_W-1:0] w_a11, w_a12, w_a21, w_a22;
    logic signed [OFFS_W-1:0] w_b1, w_b2;
    logic signed [COL_W:0]    w_col_s;
    logic signed [ROW_W:0]    w_row_s;

    assign w_a11   = i_row0_model[63:48];
    assign w_a12   = i_row0_model[47:32];
    assign w_b1    = i_row0_model[31:0];
    assign w_a21   = i_row1_model[63:48];
    assign w_a22   = i_row1_model[47:32];
    assign w_b2    = i_row1_model[31:0];
    assign w_col_s = $signed({1'b0, i_col});
    assign w_row_s = $signed({1'b0, i_row});

    // stage 2: coefficient products
    logic signed [PROD_W-1:0] r2_x_col, r2_x_row, r2_y_col, r2_y_row;
    logic [COL_W-1:0]         r2_col;
    logic [ROW_W-1:0]         r2_row;
    logic signed [FLOW_W-1:0] r2_fx, r2_fy;

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r2_x_col <= PROD_W'(w_a11) * PROD_W'(w_col_s);
            r2_x_row <= PROD_W'(w_a12) * PROD_W'(w_row_s);
            r2_y_col <= PROD_W'(w_a21) * PROD_W'(w_col_s);
            r2_y_row <= PROD_W'(w_a22) * PROD_W'(w_row_s);
            r2_col   <= i_col;
            r2_row   <= i_row;
            r2_fx    <= i_flow_x;
            r2_fy    <= i_flow_y;
        end
    end

    // stage 3: planar flow in Q.16, rounded to Q.6
    logic signed [Q_W-1:0]    n_q16_x, n_q16_y;
    logic signed [PRED_W-1:0] r3_pred_x, r3_pred_y;
    logic signed [FLOW_W-1:0] r3_fx, r3_fy;

    always_comb begin
        n_q16_x = (Q_W'(r2_x_col) <<< 4) + (Q_W'(r2_x_row) <<< 4) + Q_W'(w_b1)
                - (Q_W'($signed({1'b0, r2_col})) <<< 16) + ROUND_HALF;
        n_q16_y = (Q_W'(r2_y_col) <<< 4) + (Q_W'(r2_y_row) <<< 4) + Q_W'(w_b2)
                - (Q_W'($signed({1'b0, r2_row})) <<< 16) + ROUND_HALF;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r3_pred_x <= PRED_W'(n_q16_x >>> 10);
            r3_pred_y <= PRED_W'(n_q16_y >>> 10);
            r3_fx     <= r2_fx;
            r3_fy     <= r2_fy;
        end
    end

    // stage 4: squared mismatch, saturated prediction
    logic signed [DIFF_W-1:0] w_dx, w_dy;
    logic signed [SQ_W-1:0]   w_sq_x, w_sq_y;
    logic signed [SQ_W-1:0]   r4_sq_x, r4_sq_y;
    logic signed [FLOW_W-1:0] r4_pred_x, r4_pred_y;

    assign w_dx   = DIFF_W'(r3_fx) - DIFF_W'(r3_pred_x);
    assign w_dy   = DIFF_W'(r3_fy) - DIFF_W'(r3_pred_y);
    assign w_sq_x = SQ_W'(w_dx) * SQ_W'(w_dx);
    assign w_sq_y = SQ_W'(w_dy) * SQ_W'(w_dy);

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r4_sq_x   <= w_sq_x;
            r4_sq_y   <= w_sq_y;
            r4_pred_x <= sat_flow(r3_pred_x);
            r4_pred_y <= sat_flow(r3_pred_y);
        end
    end

    // stage 5: distance test
    logic [SUMSQ_W-1:0]       w_sum_sq;
    logic                     r5_hit;
    logic signed [FLOW_W-1:0] r5_pred_x, r5_pred_y;

    assign w_sum_sq = SUMSQ_W'($unsigned(r4_sq_x)) + SUMSQ_W'($unsigned(r4_sq_y));

    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            r5_hit    <= w_sum_sq < SUMSQ_W'(i_lim_sq);
            r5_pred_x <= r4_pred_x;
            r5_pred_y <= r4_pred_y;
        end
    end

    assign o_hit    = r5_hit;
    assign o_pred_x = r5_pred_x;
    assign o_pred_y = r5_pred_y;

endmodule

// ----- sv/dpc_level_store.sv -----
`timescale 1ns / 1ps

module dpc_level_store
    import dpc_pkg::*;
#(
    parameter int DEPTH  = 131072,
    parameter int ADDR_W = 17
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_we,
    input  logic [ADDR_W-1:0]  i_waddr,
    input  logic [LEVEL_W-1:0] i_wdata,
    input  logic               i_re,
    input  logic [ADDR_W-1:0]  i_raddr,
    output logic [LEVEL_W-1:0] o_rdata,
    output logic               o_busy
);

    logic [LEVEL_W-1:0] r_mem [0:DEPTH-1];
    logic [LEVEL_W-1:0] r_rdata;
    logic               r_clearing;
    logic [ADDR_W-1:0]  r_clr_addr;

    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [LEVEL_W-1:0] w_wdata;

    assign w_we    = r_clearing | i_we;
    assign w_waddr = r_clearing ? r_clr_addr : i_waddr;
    assign w_wdata = r_clearing ? '0 : i_wdata;

    // sweep every entry to zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clearing;

endmodule

// ----- sv/dominant_plane_pixel_classifier.sv -----
`timescale 1ns / 1ps

// Classifies one pixel per clock while o_stall is low, against two affine
// flow-plane models, and low-pass filters the main-model match against the
// level kept for the same pixel in an on-chip frame store. A new beat is
// taken every cycle that o_stall is low, and bubbles in the pipe are closed
// up while the output is held. The level store has one read and one write per
// cycle; the read-modify-write of a pixel is forwarded, so repeated pixels
// back to back are handled at full rate. After reset all MAX_COLUMNS*MAX_ROWS
// store entries (131072 at the default size) are swept to zero, one entry per
// cycle, with o_stall high; configuration writes are taken at any time but
// should only be made while no beat is in flight.
module dominant_plane_pixel_classifier
    import dpc_pkg::*;
#(
    parameter int MAX_COLUMNS = 512,
    parameter int MAX_ROWS    = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data,

    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [COL_W-1:0]         i_pixel_column,
    input  logic [ROW_W-1:0]         i_pixel_row,
    input  logic signed [FLOW_W-1:0] i_flow_x,
    input  logic signed [FLOW_W-1:0] i_flow_y,
    input  logic signed [FLOW_W-1:0] i_second_flow_x,
    input  logic signed [FLOW_W-1:0] i_second_flow_y,

    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_plane_mask,
    output logic [LEVEL_W-1:0]       o_smoothed_level,
    output logic                     o_second_match,
    output logic signed [FLOW_W-1:0] o_predicted_x,
    output logic signed [FLOW_W-1:0] o_predicted_y,
    output logic signed [FLOW_W-1:0] o_second_predicted_x,
    output logic signed [FLOW_W-1:0] o_second_predicted_y
);

    localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);

    // configuration
    logic [CFG_W-1:0]    r_main_row0, r_main_row1, r_second_row0, r_second_row1;
    logic [DIST_W-1:0]   r_match_distance;
    logic [GAIN_W-1:0]   r_smoothing_gain;
    logic [LEVEL_W-1:0]  r_mask_threshold;
    logic [LIM_SQ_W-1:0] r_lim_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_row0      <= '0;
            r_main_row1      <= '0;
            r_second_row0    <= '0;
            r_second_row1    <= '0;
            r_match_distance <= MATCH_DISTANCE_RST;
            r_smoothing_gain <= SMOOTHING_GAIN_RST;
            r_mask_threshold <= MASK_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MAIN_ROW0:      r_main_row0      <= i_cfg_data;
                CFG_MAIN_ROW1:      r_main_row1      <= i_cfg_data;
                CFG_SECOND_ROW0:    r_second_row0    <= i_cfg_data;
                CFG_SECOND_ROW1:    r_second_row1    <= i_cfg_data;
                CFG_MATCH_DISTANCE: r_match_distance <= i_cfg_data[DIST_W-1:0];
                CFG_SMOOTHING_GAIN: r_smoothing_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_MASK_THRESHOLD: r_mask_threshold <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim_sq <= LIM_SQ_W'(r_match_distance) * LIM_SQ_W'(r_match_distance);
    end

    // stage valids and advance enables
    logic [7:1] r_v;
    logic [7:1] w_en;
    logic       w_busy;
    logic       w_accept;

    always_comb begin
        w_en[7] = ~r_v[7] | ~i_stall;
        for (int k = 6; k >= 1; k--) begin
            w_en[k] = ~r_v[k] | w_en[k+1];
        end
    end

    assign o_stall  = w_busy | ~w_en[1];
    assign w_accept = i_valid & ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[1]) begin
                r_v[1] <= w_accept;
            end
            for (int k = 2; k <= 7; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 1: input beat, store address
    logic [COL_W-1:0]         r1_col;
    logic [ROW_W-1:0]         r1_row;
    logic signed [FLOW_W-1:0] r1_fx, r1_fy, r1_sfx, r1_sfy;
    logic [ADDR_W-1:0]        r_addr   [1:6];
    logic                     r_inside [1:6];
    logic [ADDR_W-1:0]        n_addr;
    logic                     n_inside;

    assign n_addr   = ADDR_W'(ADDR_W'(i_pixel_row) * ADDR_W'(MAX_COLUMNS))
                    + ADDR_W'(i_pixel_column);
    assign n_inside = (32'(i_pixel_column) < 32'(MAX_COLUMNS))
                    & (32'(i_pixel_row) < 32'(MAX_ROWS));

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_col      <= i_pixel_column;
            r1_row      <= i_pixel_row;
            r1_fx       <= i_flow_x;
            r1_fy       <= i_flow_y;
            r1_sfx      <= i_second_flow_x;
            r1_sfy      <= i_second_flow_y;
            r_addr[1]   <= n_addr;
            r_inside[1] <= n_inside;
        end
        for (int k = 2; k <= 6; k++) begin
            if (w_en[k]) begin
                r_addr[k]   <= r_addr[k-1];
                r_inside[k] <= r_inside[k-1];
            end
        end
    end

    // stages 2 to 5: plane models
    t_lane_en w_lane_en;
    logic     w_main_hit, w_second_hit;
    logic signed [FLOW_W-1:0] w_px, w_py, w_spx, w_spy;

    assign w_lane_en = '{s2: w_en[2], s3: w_en[3], s4: w_en[4], s5: w_en[5]};

    dpc_plane_lane u_main_lane (
        .i_clk        (i_clk),
        .i_en         (w_lane_en),
        .i_col        (r1_col),
        .i_row        (r1_row),
        .i_flow_x     (r1_fx),
        .i_flow_y     (r1_fy),
        .i_row0_model (r_main_row0),
        .i_row1_model (r_main_row1),
        .i_lim_sq     (r_lim_sq),
        .o_hit        (w_main_hit),
        .o_pred_x     (w_px),
        .o_pred_y     (w_py)
    );

    dpc_plane_lane u_second_lane (
        .i_clk        (i_clk),
        .i_en         (w_lane_en),
        .i_col        (r1_col),
        .i_row        (r1_row),
        .i_flow_x     (r1_sfx),
        .i_flow_y     (r1_sfy),
        .i_row0_model (r_second_row0),
        .i_row1_model (r_second_row1),
        .i_lim_sq     (r_lim_sq),
        .o_hit        (w_second_hit),
        .o_pred_x     (w_spx),
        .o_pred_y     (w_spy)
    );

    // stage 6: previous level, filter, write back
    logic                     r6_hit, r6_second_hit;
    logic signed [FLOW_W-1:0] r6_px, r6_py, r6_spx, r6_spy;
    logic                     r6_fwd;
    logic [LEVEL_W-1:0]       r6_fwd_level;
    logic [LEVEL_W-1:0]       w_rdata;
    logic [LEVEL_W-1:0]       w_prev;
    logic [GAIN_W-1:0]        w_alpha;
    logic [GAIN_W-1:0]        w_mul_a;
    logic [LEVEL_W-1:0]       w_mul_b;
    logic [FILT_W-1:0]        w_prod;
    logic [LEVEL_W:0]         w_sum;
    logic [LEVEL_W-1:0]       w_level;
    logic                     w_we;

    assign w_prev  = !r_inside[6] ? '0 : (r6_fwd ? r6_fwd_level : w_rdata);
    assign w_alpha = (r_smoothing_gain > UNITY_GAIN) ? UNITY_GAIN : r_smoothing_gain;
    assign w_mul_a = r6_hit ? w_alpha : UNITY_GAIN - w_alpha;
    assign w_mul_b = r6_hit ? FULL_LEVEL - w_prev : w_prev;
    assign w_prod  = FILT_W'(w_mul_a) * FILT_W'(w_mul_b);
    assign w_sum   = r6_hit ? ({1'b0, w_prev} + w_prod[LEVEL_W+16:16])
                            : w_prod[LEVEL_W+16:16];
    assign w_level = w_sum[LEVEL_W] ? FULL_LEVEL : w_sum[LEVEL_W-1:0];
    assign w_we    = w_en[7] & r_v[6] & r_inside[6];

    dpc_level_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (r_addr[6]),
        .i_wdata (w_level),
        .i_re    (w_en[6]),
        .i_raddr (r_addr[5]),
        .o_rdata (w_rdata),
        .o_busy  (w_busy)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r6_hit        <= w_main_hit;
            r6_second_hit <= w_second_hit;
            r6_px         <= w_px;
            r6_py         <= w_py;
            r6_spx        <= w_spx;
            r6_spy        <= w_spy;
            // bypass the level being written this edge
            r6_fwd        <= w_we & (r_addr[5] == r_addr[6]);
            r6_fwd_level  <= w_level;
        end
    end

    // stage 7: output register
    logic                     r7_mask, r7_second_hit;
    logic [LEVEL_W-1:0]       r7_level;
    logic signed [FLOW_W-1:0] r7_px, r7_py, r7_spx, r7_spy;

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r7_mask       <= w_level > r_mask_threshold;
            r7_level      <= w_level;
            r7_second_hit <= r6_second_hit;
            r7_px         <= r6_px;
            r7_py         <= r6_py;
            r7_spx        <= r6_spx;
            r7_spy        <= r6_spy;
        end
    end

    assign o_valid              = r_v[7];
    assign o_plane_mask         = r7_mask;
    assign o_smoothed_level     = r7_level;
    assign o_second_match       = r7_second_hit;
    assign o_predicted_x        = r7_px;
    assign o_predicted_y        = r7_py;
    assign o_second_predicted_x = r7_spx;
    assign o_second_predicted_y = r7_spy;

endmodule
